// ===== hw/rtl/ctbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Curvature/tank blend drive mixer package
// Shared constants, register indexes, stage payload types and the curve ROM
// builder used by the drive mixer modules.
// ----------------------------------------------------------------------------
package ctbm_pkg;

   // Stick and fixed-point scale constants.
   localparam int STICK_MAX = 127;
   localparam int FULL_Q = 32512;
   localparam logic [31:0] FULL_Q_SQ = 32'd1057030144;
   localparam logic [13:0] FULL_SQ_ODD = 14'd16129;
   localparam logic [16:0] ONE_I = 17'h10000;
   localparam logic [48:0] ROUND_HALF = 49'd1065353216;
   localparam logic [16:0] RECIP_127 = 17'd66052;
   localparam logic [6:0] DIV_127 = 7'd127;

   // Curve exponent limits and defaults, in tenths.
   localparam int CURVE_MIN = 10;
   localparam int CURVE_MAX = 30;
   localparam int THROTTLE_CURVE_DEFAULT = 12;
   localparam int TURN_CURVE_DEFAULT = 14;

   // Register reset values.
   localparam logic [6:0] THROTTLE_DB_RESET = 7'd3;
   localparam logic [6:0] TURN_DB_RESET = 7'd3;
   localparam logic [6:0] BLEND_START_RESET = 7'd2;
   localparam logic [6:0] BLEND_END_RESET = 7'd50;
   localparam logic [8:0] TURN_GAIN_RESET = 9'd282;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_THROTTLE_DB = 3'd0,
      REG_TURN_DB     = 3'd1,
      REG_BLEND_START = 3'd2,
      REG_BLEND_END   = 3'd3,
      REG_TURN_GAIN   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [6:0] throttle_deadband;
      logic [6:0] turn_deadband;
      logic [6:0] blend_start;
      logic [6:0] blend_end;
      logic [8:0] turn_gain;
   } cfg_type;

   typedef logic [14:0] curve_rom_type [128];

   // Products handed from the shaper to the normalising divider.
   typedef struct packed {
      logic [14:0]        fm;
      logic [31:0]        fmm;
      logic [16:0]        m;
      logic [30:0]        pa;
      logic [30:0]        pb;
      logic               sa;
      logic               sb;
      logic signed [33:0] ca;
      logic signed [33:0] cb;
      logic signed [15:0] kl;
      logic signed [15:0] kr;
   } mix_type;

   // Curvature and tank terms with the interpolator, handed to the blender.
   typedef struct packed {
      logic signed [31:0] cl;
      logic signed [31:0] cr;
      logic signed [15:0] kl;
      logic signed [15:0] kr;
      logic [16:0]        itp;
   } blend_in_type;

   // Largest y with y^10 * 127^p <= m^p * 32512^10, found by binary search.
   function automatic logic [14:0] curve_entry(input int m, input int p);
      logic [383:0] rhs;
      logic [383:0] lhs;
      int lo;
      int hi;
      int mid;
      rhs = 384'd1;
      for (int k = 0; k < p; k++) rhs = rhs * 384'(m);
      for (int k = 0; k < 10; k++) rhs = rhs * 384'(FULL_Q);
      lo = 0;
      hi = FULL_Q;
      for (int it = 0; it < 16; it++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 384'd1;
            for (int k = 0; k < 10; k++) lhs = lhs * 384'(mid);
            for (int k = 0; k < p; k++) lhs = lhs * 384'(STICK_MAX);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
      end
      return 15'(lo);
   endfunction

   // Whole curve table for one exponent, clamped into its legal range.
   function automatic curve_rom_type curve_rom(input int p);
      curve_rom_type rom;
      int pc;
      pc = (p < CURVE_MIN) ? CURVE_MIN : ((p > CURVE_MAX) ? CURVE_MAX : p);
      for (int m = 0; m <= STICK_MAX; m++) rom[m] = curve_entry(m, pc);
      return rom;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ctbm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Drive mixer channel interfaces
// Valid/ready channels for the stick pair and for the motor drive pair.
// ----------------------------------------------------------------------------
interface ctbm_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] throttle;
   logic signed [7:0] turn;
   modport source (output valid, throttle, turn, input ready);
   modport sink (input valid, throttle, turn, output ready);
endinterface

interface ctbm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_power;
   logic signed [15:0] right_power;
   modport source (output valid, left_power, right_power, input ready);
   modport sink (input valid, left_power, right_power, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/curvature_tank_blend_drive_mixer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Curvature/tank blend drive mixer
// Turns a throttle and turn stick pair into left and right motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one stick pair per item (signed 8-bit throttle and turn);
//   rsp_chan returns one item per stick pair, left_power and right_power in
//   signed Q7.8. Both are valid/ready channels; items are never reordered.
//   Deadbands, blend thresholds and turn gain are set over the csr_ APB port
//   while no item is in flight; pready is always high.
//   The datapath is a 15-stage pipeline (shaper 6, divider 5, blender 4), and
//   one item per cycle is sustained while rsp_chan.ready stays high. The
//   30-bit curvature normalisation divide, spread over four stages, sets the
//   depth.
//   When rsp_chan.ready is low, items back up stage by stage; req_chan.ready
//   stays high until every stage holds an item, and nothing is lost.
//   Reset (synchronous, active high) empties the pipeline and returns the
//   registers to their defaults. The curve ROMs are built at elaboration from
//   the exponent parameters.
// ----------------------------------------------------------------------------
module curvature_tank_blend_drive_mixer_top import ctbm_pkg::*; #(
   parameter int THROTTLE_CURVE_TENTHS = THROTTLE_CURVE_DEFAULT,
   parameter int TURN_CURVE_TENTHS = TURN_CURVE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ctbm_req_if.sink    req_chan,
   ctbm_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type      cfg;
   mix_type      mix;
   logic         mix_valid, mix_ready;
   blend_in_type bin;
   logic         bin_valid, bin_ready;

   ctbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ctbm_shaper #(
      .THROTTLE_CURVE_TENTHS (THROTTLE_CURVE_TENTHS),
      .TURN_CURVE_TENTHS     (TURN_CURVE_TENTHS)
   ) u_shaper (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .throttle  (req_chan.throttle),
      .turn      (req_chan.turn),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix)
   );

   ctbm_norm_div u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_data   (mix),
      .out_valid (bin_valid),
      .out_ready (bin_ready),
      .out_data  (bin)
   );

   ctbm_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (bin_valid),
      .in_ready    (bin_ready),
      .in_data     (bin),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .left_power  (rsp_chan.left_power),
      .right_power (rsp_chan.right_power)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/ctbm_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Drive mixer configuration registers
// APB-style register bank holding the deadbands, blend thresholds and gain.
// ----------------------------------------------------------------------------
module ctbm_csr import ctbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en = psel & penable & pwrite;
   assign cfg = cfg_ff;

   // Write decode; unknown indexes leave the bank untouched.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            REG_THROTTLE_DB: cfg_in.throttle_deadband = pwdata[6:0];
            REG_TURN_DB:     cfg_in.turn_deadband = pwdata[6:0];
            REG_BLEND_START: cfg_in.blend_start = pwdata[6:0];
            REG_BLEND_END:   cfg_in.blend_end = pwdata[6:0];
            REG_TURN_GAIN:   cfg_in.turn_gain = pwdata[8:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_deadband <= THROTTLE_DB_RESET;
         cfg_ff.turn_deadband <= TURN_DB_RESET;
         cfg_ff.blend_start <= BLEND_START_RESET;
         cfg_ff.blend_end <= BLEND_END_RESET;
         cfg_ff.turn_gain <= TURN_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (paddr[4:2])
         REG_THROTTLE_DB: prdata = {25'd0, cfg_ff.throttle_deadband};
         REG_TURN_DB:     prdata = {25'd0, cfg_ff.turn_deadband};
         REG_BLEND_START: prdata = {25'd0, cfg_ff.blend_start};
         REG_BLEND_END:   prdata = {25'd0, cfg_ff.blend_end};
         REG_TURN_GAIN:   prdata = {23'd0, cfg_ff.turn_gain};
         default:         prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ctbm_shaper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Drive mixer stick shaper
// Six-stage pipeline: deadband and curve ROM, turn gain, rounding, mix terms,
// magnitudes and the products that feed the normalising divider.
// ----------------------------------------------------------------------------
module ctbm_shaper import ctbm_pkg::*; #(
   parameter int THROTTLE_CURVE_TENTHS = THROTTLE_CURVE_DEFAULT,
   parameter int TURN_CURVE_TENTHS = TURN_CURVE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic signed [7:0] throttle,
   input  logic signed [7:0] turn,
   output logic              out_valid,
   input  logic              out_ready,
   output mix_type           out_data
);

   localparam int NSTAGE = 6;
   localparam curve_rom_type THR_ROM = curve_rom(THROTTLE_CURVE_TENTHS);
   localparam curve_rom_type TRN_ROM = curve_rom(TURN_CURVE_TENTHS);

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;

   logic signed [15:0] s1_f_ff, s1_f_in, s1_t_ff, s1_t_in;
   logic signed [15:0] s2_f_ff;
   logic signed [25:0] s2_tprod_ff, s2_tprod_in;
   logic signed [15:0] s3_f_ff;
   logic signed [17:0] s3_tg_ff, s3_tg_in;
   logic [14:0]        s4_fm_ff, s4_fm_in;
   logic signed [17:0] s4_a_ff, s4_a_in, s4_b_ff, s4_b_in;
   logic signed [15:0] s4_kl_ff, s4_kl_in, s4_kr_ff, s4_kr_in;
   logic [14:0]        s5_fm_ff;
   logic signed [17:0] s5_a_ff, s5_b_ff;
   logic [16:0]        s5_am_ff, s5_am_in, s5_bm_ff, s5_bm_in, s5_m_ff, s5_m_in;
   logic signed [15:0] s5_kl_ff, s5_kr_ff;
   mix_type            s6_ff, s6_in;

   // Saturate, deadband and look up the curve, keeping the stick's sign.
   function automatic logic signed [15:0] shape(input logic [7:0] raw,
                                                input logic [6:0] band,
                                                input curve_rom_type rom);
      logic [7:0]  mag8;
      logic [6:0]  mag;
      logic [15:0] val;
      mag8 = raw[7] ? (8'd0 - raw) : raw;
      mag = mag8[7] ? 7'd127 : mag8[6:0];
      val = {1'b0, rom[mag]};
      if (mag < band) return 16'sd0;
      return raw[7] ? $signed(16'd0 - val) : $signed(val);
   endfunction

   // Clip a mix term to full scale.
   function automatic logic signed [15:0] clip_q(input logic signed [17:0] x);
      if (x > 18'sd32512) return 16'sd32512;
      if (x < -18'sd32512) return -16'sd32512;
      return 16'(x);
   endfunction

   // Stall chain: a stage loads when it is empty or its successor moves.
   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] | out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) adv[k] = !valid_ff[k] | adv[k+1];
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
   end

   assign in_ready = adv[0];
   assign out_valid = valid_ff[NSTAGE-1];
   assign out_data = s6_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   // Stage 1: curve shaping of both sticks.
   always_comb begin
      s1_f_in = shape(throttle, cfg.throttle_deadband, THR_ROM);
      s1_t_in = shape(turn, cfg.turn_deadband, TRN_ROM);
   end

   // Stage 2: turn times gain.
   assign s2_tprod_in = 26'(s1_t_ff) * 26'($signed({1'b0, cfg.turn_gain}));

   // Stage 3: round the scaled turn back to Q7.8, halves away from zero.
   always_comb begin
      logic [24:0] tp_mag;
      logic [16:0] tg_mag;
      tp_mag = s2_tprod_ff[25] ? 25'(-s2_tprod_ff) : 25'(s2_tprod_ff);
      tg_mag = 17'((tp_mag + 25'd128) >> 8);
      s3_tg_in = s2_tprod_ff[25] ? -$signed({1'b0, tg_mag}) : $signed({1'b0, tg_mag});
   end

   // Stage 4: curvature factors and clipped tank terms.
   always_comb begin
      logic signed [17:0] fs;
      logic signed [17:0] f18;
      fs = s3_f_ff[15] ? -18'sd32512 : 18'sd32512;
      f18 = 18'(s3_f_ff);
      s4_fm_in = s3_f_ff[15] ? 15'(-s3_f_ff) : 15'(s3_f_ff);
      s4_a_in = fs + s3_tg_ff;
      s4_b_in = fs - s3_tg_ff;
      s4_kl_in = clip_q(f18 + s3_tg_ff);
      s4_kr_in = clip_q(f18 - s3_tg_ff);
   end

   // Stage 5: magnitudes and the larger one.
   always_comb begin
      s5_am_in = s4_a_ff[17] ? 17'(-s4_a_ff) : 17'(s4_a_ff);
      s5_bm_in = s4_b_ff[17] ? 17'(-s4_b_ff) : 17'(s4_b_ff);
      s5_m_in = (s5_am_in > s5_bm_in) ? s5_am_in : s5_bm_in;
   end

   // Stage 6: products for the normalisation test, the dividend and the plain terms.
   always_comb begin
      s6_in.fm = s5_fm_ff;
      s6_in.fmm = 32'(s5_fm_ff) * 32'(s5_m_ff);
      s6_in.m = s5_m_ff;
      s6_in.pa = 31'(s5_am_ff) * 31'(FULL_SQ_ODD);
      s6_in.pb = 31'(s5_bm_ff) * 31'(FULL_SQ_ODD);
      s6_in.sa = s5_a_ff[17];
      s6_in.sb = s5_b_ff[17];
      s6_in.ca = 34'($signed({1'b0, s5_fm_ff})) * 34'(s5_a_ff);
      s6_in.cb = 34'($signed({1'b0, s5_fm_ff})) * 34'(s5_b_ff);
      s6_in.kl = s5_kl_ff;
      s6_in.kr = s5_kr_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_f_ff <= s1_f_in;
         s1_t_ff <= s1_t_in;
      end
      if (adv[1]) begin
         s2_f_ff <= s1_f_ff;
         s2_tprod_ff <= s2_tprod_in;
      end
      if (adv[2]) begin
         s3_f_ff <= s2_f_ff;
         s3_tg_ff <= s3_tg_in;
      end
      if (adv[3]) begin
         s4_fm_ff <= s4_fm_in;
         s4_a_ff <= s4_a_in;
         s4_b_ff <= s4_b_in;
         s4_kl_ff <= s4_kl_in;
         s4_kr_ff <= s4_kr_in;
      end
      if (adv[4]) begin
         s5_fm_ff <= s4_fm_ff;
         s5_a_ff <= s4_a_ff;
         s5_b_ff <= s4_b_ff;
         s5_am_ff <= s5_am_in;
         s5_bm_ff <= s5_bm_in;
         s5_m_ff <= s5_m_in;
         s5_kl_ff <= s4_kl_ff;
         s5_kr_ff <= s4_kr_ff;
      end
      if (adv[5]) s6_ff <= s6_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ctbm_norm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Drive mixer normalising divider
// Set-up stage and four restoring-division stages: curvature normalisation
// (30 quotient bits per side) and the blend interpolator (16 bits) in lanes.
// ----------------------------------------------------------------------------
module ctbm_norm_div import ctbm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  mix_type      in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output blend_in_type out_data
);

   localparam int NSTAGE = 5;

   typedef struct packed {
      logic               norm;
      logic               sa;
      logic               sb;
      logic [16:0]        m;
      logic [46:0]        cx;
      logic [46:0]        cy;
      logic signed [33:0] ca;
      logic signed [33:0] cb;
      logic signed [15:0] kl;
      logic signed [15:0] kr;
      logic               ifix;
      logic [16:0]        ival;
      logic [22:0]        ix;
      logic [6:0]         d;
   } div_stage_type;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;
   div_stage_type     st_ff [NSTAGE];
   div_stage_type     st_in [NSTAGE];

   // Up to eight restoring steps on the curvature dividend (remainder over
   // the top 17 bits, quotient shifting in at the bottom).
   function automatic logic [46:0] cdiv(input logic [46:0] x, input logic [16:0] m,
                                        input int n);
      logic [17:0] t;
      logic [16:0] r;
      logic [29:0] lo;
      r = x[46:30];
      lo = x[29:0];
      for (int i = 0; i < 8; i++) begin
         if (i < n) begin
            t = {r, lo[29]};
            if (t >= {1'b0, m}) begin
               r = 17'(t - {1'b0, m});
               lo = {lo[28:0], 1'b1};
            end else begin
               r = t[16:0];
               lo = {lo[28:0], 1'b0};
            end
         end
      end
      return {r, lo};
   endfunction

   // Four restoring steps on the interpolator dividend.
   function automatic logic [22:0] idiv(input logic [22:0] x, input logic [6:0] d);
      logic [7:0]  t;
      logic [6:0]  r;
      logic [15:0] lo;
      r = x[22:16];
      lo = x[15:0];
      for (int i = 0; i < 4; i++) begin
         t = {r, lo[15]};
         if (t >= {1'b0, d}) begin
            r = 7'(t - {1'b0, d});
            lo = {lo[14:0], 1'b1};
         end else begin
            r = t[6:0];
            lo = {lo[14:0], 1'b0};
         end
      end
      return {r, lo};
   endfunction

   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] | out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) adv[k] = !valid_ff[k] | adv[k+1];
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
   end

   assign in_ready = adv[0];
   assign out_valid = valid_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   // Set-up: normalisation test, rounded dividends and the interpolator case.
   always_comb begin
      logic [14:0] st;
      logic [14:0] diff;
      logic [22:0] numer;
      logic [6:0]  d;
      st = {cfg.blend_start, 8'd0};
      diff = in_data.fm - st;
      numer = {diff, 8'd0};
      d = cfg.blend_end - cfg.blend_start;
      st_in[0].norm = in_data.fmm > FULL_Q_SQ;
      st_in[0].sa = in_data.sa;
      st_in[0].sb = in_data.sb;
      st_in[0].m = in_data.m;
      st_in[0].cx = {in_data.pa, in_data.m[16:1]};
      st_in[0].cy = {in_data.pb, in_data.m[16:1]};
      st_in[0].ca = in_data.ca;
      st_in[0].cb = in_data.cb;
      st_in[0].kl = in_data.kl;
      st_in[0].kr = in_data.kr;
      st_in[0].d = d;
      st_in[0].ix = numer;
      st_in[0].ifix = 1'b1;
      st_in[0].ival = 17'd0;
      if (cfg.blend_end <= cfg.blend_start) begin
         // Degenerate ramp: a step at the start threshold.
         st_in[0].ival = (in_data.fm >= st) ? ONE_I : 17'd0;
      end else if (in_data.fm <= st) begin
         st_in[0].ival = 17'd0;
      end else if (numer >= {d, 16'd0}) begin
         st_in[0].ival = ONE_I;
      end else begin
         st_in[0].ifix = 1'b0;
      end
   end

   // Division stages: 8, 8, 8 and 6 curvature steps, 4 interpolator steps each.
   always_comb begin
      for (int k = 1; k < NSTAGE; k++) begin
         st_in[k] = st_ff[k-1];
         st_in[k].cx = cdiv(st_ff[k-1].cx, st_ff[k-1].m, (k == NSTAGE - 1) ? 6 : 8);
         st_in[k].cy = cdiv(st_ff[k-1].cy, st_ff[k-1].m, (k == NSTAGE - 1) ? 6 : 8);
         st_in[k].ix = idiv(st_ff[k-1].ix, st_ff[k-1].d);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (adv[k]) st_ff[k] <= st_in[k];
      end
   end

   // Pick the normalised or plain curvature term and the interpolator.
   always_comb begin
      logic signed [31:0] qa;
      logic signed [31:0] qb;
      qa = $signed({2'b00, st_ff[NSTAGE-1].cx[29:0]});
      qb = $signed({2'b00, st_ff[NSTAGE-1].cy[29:0]});
      out_data.cl = st_ff[NSTAGE-1].norm ? (st_ff[NSTAGE-1].sa ? -qa : qa)
                                         : 32'(st_ff[NSTAGE-1].ca);
      out_data.cr = st_ff[NSTAGE-1].norm ? (st_ff[NSTAGE-1].sb ? -qb : qb)
                                         : 32'(st_ff[NSTAGE-1].cb);
      out_data.kl = st_ff[NSTAGE-1].kl;
      out_data.kr = st_ff[NSTAGE-1].kr;
      out_data.itp = st_ff[NSTAGE-1].ifix ? st_ff[NSTAGE-1].ival
                                          : {1'b0, st_ff[NSTAGE-1].ix[15:0]};
   end

`ifndef SYNTH
   // The interpolator never exceeds one.
   a_itp_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.itp <= ONE_I))
      else $error("interpolator above one");

   // A normalised quotient never exceeds full scale squared.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid && st_ff[NSTAGE-1].norm) |->
         ({2'b00, st_ff[NSTAGE-1].cx[29:0]} <= FULL_Q_SQ &&
          {2'b00, st_ff[NSTAGE-1].cy[29:0]} <= FULL_Q_SQ))
      else $error("curvature quotient out of range");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ctbm_blend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Drive mixer blender
// Four-stage pipeline: weighted products, sum and rounding shift, reciprocal
// multiply by 1/127 and its correction into the output register.
// ----------------------------------------------------------------------------
module ctbm_blend import ctbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  blend_in_type       in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] left_power,
   output logic signed [15:0] right_power
);

   localparam int NSTAGE = 4;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;

   logic signed [48:0] f1_pl_ff, f1_pl_in, f1_pr_ff, f1_pr_in;
   logic signed [33:0] f1_ql_ff, f1_ql_in, f1_qr_ff, f1_qr_in;
   logic [21:0]        f2_yl_ff, f2_yl_in, f2_yr_ff, f2_yr_in;
   logic               f2_nl_ff, f2_nl_in, f2_nr_ff, f2_nr_in;
   logic [21:0]        f3_yl_ff, f3_yr_ff;
   logic [38:0]        f3_ml_ff, f3_ml_in, f3_mr_ff, f3_mr_in;
   logic               f3_nl_ff, f3_nr_ff;
   logic signed [15:0] f4_l_ff, f4_l_in, f4_r_ff, f4_r_in;

   // Sum the weighted terms and take magnitude + half divisor, over 2^24.
   function automatic logic [22:0] sum_shift(input logic signed [48:0] p,
                                             input logic signed [33:0] q);
      logic signed [49:0] n;
      logic [48:0]        mag;
      logic [48:0]        x;
      n = 50'(p) + (50'(q) <<< 15) - (50'(q) <<< 8);
      mag = n[49] ? 49'(-n) : 49'(n);
      x = mag + ROUND_HALF;
      return {n[49], 22'(x >> 24)};
   endfunction

   // Finish the division by 127 and restore the sign.
   function automatic logic signed [15:0] fix127(input logic [38:0] prod,
                                                 input logic [21:0] y, input logic neg);
      logic [15:0] q;
      logic [22:0] qq;
      logic [22:0] r;
      q = prod[38:23];
      qq = {q, 7'd0} - {7'd0, q};
      r = {1'b0, y} - qq;
      if (r >= 23'(DIV_127)) q = q + 16'd1;
      return neg ? $signed(16'd0 - q) : $signed(q);
   endfunction

   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] | out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) adv[k] = !valid_ff[k] | adv[k+1];
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
   end

   assign in_ready = adv[0];
   assign out_valid = valid_ff[NSTAGE-1];
   assign left_power = f4_l_ff;
   assign right_power = f4_r_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   // Stage 1: curvature times I and tank times (1 - I).
   always_comb begin
      logic signed [17:0] wi;
      logic signed [17:0] wt;
      wi = $signed({1'b0, in_data.itp});
      wt = $signed({1'b0, 17'(ONE_I - in_data.itp)});
      f1_pl_in = 49'(in_data.cl) * 49'(wi);
      f1_pr_in = 49'(in_data.cr) * 49'(wi);
      f1_ql_in = 34'(in_data.kl) * 34'(wt);
      f1_qr_in = 34'(in_data.kr) * 34'(wt);
   end

   // Stage 2: sum, round and drop the power-of-two part of the divisor.
   always_comb begin
      {f2_nl_in, f2_yl_in} = sum_shift(f1_pl_ff, f1_ql_ff);
      {f2_nr_in, f2_yr_in} = sum_shift(f1_pr_ff, f1_qr_ff);
   end

   // Stage 3: reciprocal multiply for the division by 127.
   assign f3_ml_in = 39'(f2_yl_ff) * 39'(RECIP_127);
   assign f3_mr_in = 39'(f2_yr_ff) * 39'(RECIP_127);

   // Stage 4: one correction step into the output register.
   assign f4_l_in = fix127(f3_ml_ff, f3_yl_ff, f3_nl_ff);
   assign f4_r_in = fix127(f3_mr_ff, f3_yr_ff, f3_nr_ff);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         f1_pl_ff <= f1_pl_in;
         f1_pr_ff <= f1_pr_in;
         f1_ql_ff <= f1_ql_in;
         f1_qr_ff <= f1_qr_in;
      end
      if (adv[1]) begin
         f2_yl_ff <= f2_yl_in;
         f2_yr_ff <= f2_yr_in;
         f2_nl_ff <= f2_nl_in;
         f2_nr_ff <= f2_nr_in;
      end
      if (adv[2]) begin
         f3_yl_ff <= f2_yl_ff;
         f3_yr_ff <= f2_yr_ff;
         f3_ml_ff <= f3_ml_in;
         f3_mr_ff <= f3_mr_in;
         f3_nl_ff <= f2_nl_ff;
         f3_nr_ff <= f2_nr_ff;
      end
      if (adv[3]) begin
         f4_l_ff <= f4_l_in;
         f4_r_ff <= f4_r_in;
      end
   end

`ifndef SYNTH
   // Drive commands stay within full scale.
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (left_power <= 16'sd32512 && left_power >= -16'sd32512))
      else $error("left drive out of range");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (right_power <= 16'sd32512 && right_power >= -16'sd32512))
      else $error("right drive out of range");
`endif

endmodule
`default_nettype wire

// ===== bench/curvature_tank_blend_drive_mixer_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Drive mixer testbench
// Sends throttle and turn stick pairs to the curvature/tank blend mixer and checks
// every motor drive item against an in-bench fixed-point model or a fixed row's
// tabled result. A short table of directed stick pairs runs first. Random phases
// follow, each with its own register setting; random gaps and stalls vary by phase.
// ----------------------------------------------------------------------------
module curvature_tank_blend_drive_mixer_top_tb;
   import ctbm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS = 5;
   localparam int CURVE_THROTTLE = 12;
   localparam int CURVE_TURN = 14;
   localparam longint SCALE = 32512;
   localparam longint UNIT_I = 65536;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic signed [7:0]  throttle;
      logic signed [7:0]  turn;
      logic               fixed;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stick_row_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } drive_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ctbm_req_if req_bus ();
   ctbm_rsp_if rsp_bus ();

   curvature_tank_blend_drive_mixer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the register file.
   logic [6:0] mir_thr_band;
   logic [6:0] mir_trn_band;
   logic [6:0] mir_start;
   logic [6:0] mir_end;
   logic [8:0] mir_gain;

   longint thr_curve [128];
   longint trn_curve [128];

   stick_row_type offered_q [$];
   drive_type drive_q [$];
   int errors;
   int idle_cycles;
   bit gaps_on;
   bit stalls_on;
   bit hold_rsp;

   // Directed stick pairs; fixed rows carry a result read straight off the maths.
   stick_row_type stick_rows [17] = '{
      '{8'sd0,    8'sd0,    1'b1, 16'sd0,      16'sd0},
      '{8'sd127,  8'sd0,    1'b1, 16'sd32512,  16'sd32512},
      '{-8'sd127, 8'sd0,    1'b1, -16'sd32512, -16'sd32512},
      '{-8'sd128, 8'sd0,    1'b1, -16'sd32512, -16'sd32512},
      '{8'sd0,    8'sd127,  1'b1, 16'sd32512,  -16'sd32512},
      '{8'sd0,    -8'sd128, 1'b1, -16'sd32512, 16'sd32512},
      '{8'sd2,    -8'sd2,   1'b1, 16'sd0,      16'sd0},
      '{8'sd1,    -8'sd1,   1'b1, 16'sd0,      16'sd0},
      '{8'sd3,    8'sd3,    1'b0, 16'sd0,      16'sd0},
      '{-8'sd3,   -8'sd3,   1'b0, 16'sd0,      16'sd0},
      '{8'sd127,  8'sd127,  1'b0, 16'sd0,      16'sd0},
      '{-8'sd127, 8'sd127,  1'b0, 16'sd0,      16'sd0},
      '{8'sd127,  -8'sd128, 1'b0, 16'sd0,      16'sd0},
      '{-8'sd128, -8'sd128, 1'b0, 16'sd0,      16'sd0},
      '{8'sd64,   -8'sd32,  1'b0, 16'sd0,      16'sd0},
      '{-8'sd5,   8'sd100,  1'b0, 16'sd0,      16'sd0},
      '{8'sd50,   8'sd50,   1'b0, 16'sd0,      16'sd0}
   };

   // Largest y with y^10 * 127^p <= m^p * 32512^10, by bisection.
   function automatic longint curve_point(int m, int p);
      logic [383:0] bound;
      logic [383:0] trial;
      longint lo;
      longint hi;
      longint mid;
      bound = 384'd1;
      for (int k = 0; k < p; k++) bound = bound * 384'(m);
      for (int k = 0; k < 10; k++) bound = bound * 384'(SCALE);
      lo = 0;
      hi = SCALE;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         trial = 384'd1;
         for (int k = 0; k < 10; k++) trial = trial * 384'(mid);
         for (int k = 0; k < p; k++) trial = trial * 384'(STICK_MAX);
         if (trial <= bound) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // Division rounded to nearest, halves away from zero; den is positive.
   function automatic longint div_nearest(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint shape_stick(logic signed [7:0] v, logic [6:0] band,
                                          bit is_turn);
      longint mag;
      longint y;
      mag = (v < 0) ? -longint'(v) : longint'(v);
      if (mag > STICK_MAX) mag = STICK_MAX;
      if (mag < band) return 0;
      y = is_turn ? trn_curve[mag] : thr_curve[mag];
      return (v < 0) ? -y : y;
   endfunction

   function automatic longint clip_full(longint x);
      return (x > SCALE) ? SCALE : ((x < -SCALE) ? -SCALE : x);
   endfunction

   // Motor drive for one stick pair under the mirrored registers.
   function automatic drive_type mix_drive(logic signed [7:0] th, logic signed [7:0] tr);
      longint f, tg, fm, itp, lc, rc, alc, arc, peak, lt, rt, st, en, sq;
      drive_type d;
      sq = SCALE * SCALE;
      st = longint'(mir_start) * 256;
      en = longint'(mir_end) * 256;
      f = shape_stick(th, mir_thr_band, 1'b0);
      tg = div_nearest(shape_stick(tr, mir_trn_band, 1'b1) * longint'(mir_gain), 256);
      fm = (f < 0) ? -f : f;
      // Step interpolator when the end threshold is not above the start.
      if (en <= st) itp = (fm >= st) ? UNIT_I : 0;
      else if (fm <= st) itp = 0;
      else begin
         itp = (fm - st) * UNIT_I / (en - st);
         if (itp > UNIT_I) itp = UNIT_I;
      end
      lc = f * SCALE + fm * tg;
      rc = f * SCALE - fm * tg;
      alc = (lc < 0) ? -lc : lc;
      arc = (rc < 0) ? -rc : rc;
      peak = (alc > arc) ? alc : arc;
      if (peak > sq) begin
         lc = div_nearest(lc * sq, peak);
         rc = div_nearest(rc * sq, peak);
      end
      lt = clip_full(f + tg) * SCALE;
      rt = clip_full(f - tg) * SCALE;
      d.left = 16'(div_nearest(lc * itp + lt * (UNIT_I - itp), SCALE * UNIT_I));
      d.right = 16'(div_nearest(rc * itp + rt * (UNIT_I - itp), SCALE * UNIT_I));
      return d;
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Expectations are formed as items go in and checked as items come out.
   always @(posedge clock) begin
      stick_row_type row;
      drive_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            row = offered_q.pop_front();
            if (row.fixed) begin
               want.left = row.left;
               want.right = row.right;
            end else begin
               want = mix_drive(row.throttle, row.turn);
            end
            drive_q.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (drive_q.size() == 0) begin
               $display("%0t: unexpected drive item %0d %0d", $realtime,
                        rsp_bus.left_power, rsp_bus.right_power);
               errors++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_bus.left_power !== want.left) begin
                  $display("%0t: left_power expected %0d actual %0d", $realtime,
                           want.left, rsp_bus.left_power);
                  errors++;
               end
               if (rsp_bus.right_power !== want.right) begin
                  $display("%0t: right_power expected %0d actual %0d", $realtime,
                           want.right, rsp_bus.right_power);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any item moving.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("curvature_tank_blend_drive_mixer_top_tb: done, errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Result side: random stalls, and one long hold-off on request.
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            n = stalls_on ? $urandom_range(0, 17) : 0;
            if (n > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic offer_sticks(stick_row_type row);
      int n;
      n = gaps_on ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      offered_q.push_back(row);
      req_bus.valid <= 1'b1;
      req_bus.throttle <= row.throttle;
      req_bus.turn <= row.turn;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic offer_random();
      stick_row_type row;
      row = '0;
      row.throttle = 8'($urandom);
      row.turn = 8'($urandom);
      // Bias towards the stick ends and the deadband edges.
      case ($urandom_range(0, 7))
         0: row.throttle = ($urandom_range(0, 1) != 0) ? 8'sd127 : -8'sd128;
         1: row.turn = ($urandom_range(0, 1) != 0) ? 8'sd127 : -8'sd128;
         2: row.throttle = 8'(mir_thr_band) - 8'($urandom_range(0, 1));
         3: row.turn = -(8'(mir_trn_band) - 8'($urandom_range(0, 1)));
         default: ;
      endcase
      offer_sticks(row);
   endtask

   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (drive_q.size() == 0 && offered_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [4:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (int'(addr >> 2))
         REG_THROTTLE_DB: mir_thr_band = value[6:0];
         REG_TURN_DB:     mir_trn_band = value[6:0];
         REG_BLEND_START: mir_start = value[6:0];
         REG_BLEND_END:   mir_end = value[6:0];
         REG_TURN_GAIN:   mir_gain = value[8:0];
         default: ;
      endcase
   endtask

   // Register value for a phase: low end, high end or random, upper bits noisy.
   function automatic logic [31:0] pick_reg(int mode, int width);
      logic [31:0] noise;
      noise = $urandom;
      noise = noise & ~((32'd1 << width) - 1);
      case (mode)
         0: return noise;
         1: return noise | ((32'd1 << width) - 1);
         default: return $urandom;
      endcase
   endfunction

   // Stimulus.
   initial begin
      int mode;
      errors = 0;
      idle_cycles = 0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_rsp = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.throttle = '0;
      req_bus.turn = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mir_thr_band = THROTTLE_DB_RESET;
      mir_trn_band = TURN_DB_RESET;
      mir_start = BLEND_START_RESET;
      mir_end = BLEND_END_RESET;
      mir_gain = TURN_GAIN_RESET;
      for (int m = 0; m <= STICK_MAX; m++) begin
         thr_curve[m] = curve_point(m, CURVE_THROTTLE);
         trn_curve[m] = curve_point(m, CURVE_TURN);
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs under the reset register values.
      foreach (stick_rows[i]) offer_sticks(stick_rows[i]);
      drain_pipe();

      // Random phases, each under a fresh register setting.
      for (int phase = 0; phase < 11; phase++) begin
         mode = (phase < 3) ? phase : 2;
         csr_write(5'(4 * REG_THROTTLE_DB), pick_reg(mode, 7));
         csr_write(5'(4 * REG_TURN_DB), pick_reg(mode, 7));
         csr_write(5'(4 * REG_BLEND_START), pick_reg(mode, 7));
         csr_write(5'(4 * REG_BLEND_END),
                   (phase == 3) ? 32'(mir_start) : pick_reg($urandom_range(0, 2), 7));
         csr_write(5'(4 * REG_TURN_GAIN), pick_reg($urandom_range(0, 2), 9));
         csr_write(5'(4 * (NUM_REGS + $urandom_range(0, 2))), $urandom);
         gaps_on = (phase % 4) != 1;
         stalls_on = (phase % 3) != 2;
         if (phase == 5) begin
            // Long result hold-off with back-to-back items filling the pipeline.
            gaps_on = 1'b0;
            hold_rsp = 1'b1;
         end
         repeat (150) offer_random();
         drain_pipe();
      end

      if (errors == 0)
         $display("curvature_tank_blend_drive_mixer_top_tb: done, clean");
      else
         $display("curvature_tank_blend_drive_mixer_top_tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/ctbm_pkg.sv
hw/rtl/ctbm_if.sv
hw/rtl/ctbm_csr.sv
hw/rtl/ctbm_shaper.sv
hw/rtl/ctbm_norm_div.sv
hw/rtl/ctbm_blend.sv
hw/rtl/curvature_tank_blend_drive_mixer_top.sv
bench/curvature_tank_blend_drive_mixer_top_tb.sv
